@@ sv/css_pkg.sv @@
package css_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    // Store access requested by the sequencer
    typedef struct packed {
        logic   we;
        idx_t   waddr;
        value_t wdata;
        idx_t   raddr;
    } mem_req_t;

    // Operands for the compare-exchange unit
    typedef struct packed {
        logic   fwd;
        value_t carry;
    } cmp_req_t;

    // Compare-exchange outcome
    typedef struct packed {
        logic   swap;
        value_t wr_value;
        value_t carry_value;
    } cmp_res_t;

    typedef enum logic [7:0] {
        ST_LOAD   = 8'b0000_0001,
        ST_FETCH  = 8'b0000_0010,
        ST_CARRY  = 8'b0000_0100,
        ST_RUN    = 8'b0000_1000,
        ST_TURN   = 8'b0001_0000,
        ST_EMRD   = 8'b0010_0000,
        ST_EMLD   = 8'b0100_0000,
        ST_EMHOLD = 8'b1000_0000
    } state_t;

endpackage

@@ sv/css_ram.sv @@
module css_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/css_cmpx.sv @@
module css_cmpx (
    input  css_pkg::cmp_req_t cmp_req,
    input  css_pkg::value_t   next_value,
    output css_pkg::cmp_res_t cmp_res
);

    import css_pkg::*;

    logic gt;

    // Forward passes carry the larger value up, backward passes the smaller down
    assign gt = cmp_req.fwd ? ($signed(cmp_req.carry) > $signed(next_value))
                            : ($signed(next_value) > $signed(cmp_req.carry));

    always_comb begin
        cmp_res.swap        = gt;
        cmp_res.wr_value    = gt ? next_value : cmp_req.carry;
        cmp_res.carry_value = gt ? cmp_req.carry : next_value;
    end

endmodule

@@ sv/css_ctrl.sv @@
module css_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [css_pkg::VALUE_WIDTH-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [css_pkg::VALUE_WIDTH-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser,
    output css_pkg::mem_req_t           mem_req,
    input  css_pkg::value_t             rd_data,
    output css_pkg::cmp_req_t           cmp_req,
    input  css_pkg::cmp_res_t           cmp_res
);

    import css_pkg::*;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    idx_t   scan_reg, scan_next;
    idx_t   low_reg, low_next;
    idx_t   high_reg, high_next;
    logic   fwd_reg, fwd_next;
    logic   swap_reg, swap_next;
    logic   ovf_reg, ovf_next;
    value_t carry_reg, carry_next;
    value_t out_data_reg, out_data_next;
    logic   out_last_reg, out_last_next;
    logic   out_ovf_reg, out_ovf_next;
    logic   out_valid_reg, out_valid_next;

    logic   in_acc;
    logic   out_acc;
    cnt_t   load_cnt;
    idx_t   scan_step;
    idx_t   high_dec;
    idx_t   low_inc;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    assign cmp_req.fwd   = fwd_reg;
    assign cmp_req.carry = carry_reg;

    assign scan_step = fwd_reg ? IDX_W'(scan_reg + 1'b1) : IDX_W'(scan_reg - 1'b1);
    assign high_dec  = IDX_W'(high_reg - 1'b1);
    assign low_inc   = IDX_W'(low_reg + 1'b1);
    assign load_cnt  = (count_reg < CNT_W'(DEPTH)) ? CNT_W'(count_reg + 1'b1) : count_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        fwd_next       = fwd_reg;
        swap_next      = swap_reg;
        ovf_next       = ovf_reg;
        carry_next     = carry_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg;
        mem_req.we     = 1'b0;
        mem_req.waddr  = scan_reg;
        mem_req.wdata  = carry_reg;
        mem_req.raddr  = scan_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    if (count_reg < CNT_W'(DEPTH)) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_reg[IDX_W-1:0];
                        mem_req.wdata = s_tdata;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    count_next = load_cnt;
                    if (s_tlast) begin
                        scan_next = '0;
                        low_next  = '0;
                        high_next = IDX_W'(load_cnt - 1'b1);
                        fwd_next  = 1'b1;
                        swap_next = 1'b0;
                        // a single element is already in order
                        state_next = (load_cnt == CNT_W'(1)) ? ST_EMRD : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_CARRY;
            end
            ST_CARRY: begin
                carry_next    = rd_data;
                mem_req.raddr = IDX_W'(scan_reg + 1'b1);
                state_next    = ST_RUN;
            end
            ST_RUN: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = cmp_res.wr_value;
                carry_next    = cmp_res.carry_value;
                swap_next     = swap_reg | cmp_res.swap;
                scan_next     = scan_step;
                if (fwd_reg ? (scan_step == high_reg) : (scan_step == low_reg)) begin
                    state_next = ST_TURN;
                end else begin
                    mem_req.raddr = fwd_reg ? IDX_W'(scan_step + 1'b1)
                                            : IDX_W'(scan_step - 1'b1);
                end
            end
            ST_TURN: begin
                // park the carried value at the end of the pass
                mem_req.we = 1'b1;
                priority if (!swap_reg) begin
                    scan_next  = '0;
                    state_next = ST_EMRD;
                end else if (fwd_reg) begin
                    if (low_reg == high_dec) begin
                        scan_next  = '0;
                        state_next = ST_EMRD;
                    end else begin
                        high_next     = high_dec;
                        fwd_next      = 1'b0;
                        swap_next     = 1'b0;
                        mem_req.raddr = IDX_W'(scan_reg - 1'b1);
                        state_next    = ST_RUN;
                    end
                end else begin
                    if (low_inc == high_reg) begin
                        scan_next  = '0;
                        state_next = ST_EMRD;
                    end else begin
                        low_next      = low_inc;
                        fwd_next      = 1'b1;
                        swap_next     = 1'b0;
                        mem_req.raddr = IDX_W'(scan_reg + 1'b1);
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_EMRD: begin
                state_next = ST_EMLD;
            end
            ST_EMLD: begin
                out_data_next  = rd_data;
                out_last_next  = (CNT_W'(scan_reg) == CNT_W'(count_reg - 1'b1));
                out_ovf_next   = ovf_reg;
                out_valid_next = 1'b1;
                state_next     = ST_EMHOLD;
            end
            ST_EMHOLD: begin
                if (out_acc) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        scan_next  = '0;
                        low_next   = '0;
                        high_next  = '0;
                        fwd_next   = 1'b1;
                        swap_next  = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        scan_next     = IDX_W'(scan_reg + 1'b1);
                        mem_req.raddr = IDX_W'(scan_reg + 1'b1);
                        state_next    = ST_EMLD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            scan_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            fwd_reg       <= 1'b1;
            swap_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            fwd_reg       <= fwd_next;
            swap_reg      <= swap_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg    <= carry_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_bounds_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN || state_reg == ST_TURN) |-> (low_reg < high_reg))
        else $error("sort bounds crossed");

    a_scan_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (fwd_reg ? (scan_reg < high_reg) : (scan_reg > low_reg)))
        else $error("scan position outside pass window");

    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count_reg == '0 && !ovf_reg))
        else $error("block not back to loading after final result");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMHOLD) |-> m_tvalid)
        else $error("result slot empty while holding");

endmodule

@@ sv/cocktail_shaker_sorter_unit.sv @@
// Cocktail shaker sorter.
// Input channel s_*: one signed 32-bit value per item in s_tdata; s_tlast marks the
// final value of a set and starts the sort. Up to 64 values are held; further items
// are dropped and every result of that set carries m_tuser = 1.
// Result channel m_*: the held values in ascending order, m_tlast on the final one.
// Loading takes one cycle per item. The sort runs on one compare-exchange
// unit over a single-port-write store: one compare per cycle, except while it
// starts (states FETCH, CARRY) and at each pass turn (write back the carried value,
// then reload the carry). After the sort, states EMRD and EMLD read and register
// the first result; after each accepted result m_tvalid drops while the next one
// is read from the store.
// s_tready is low from the last item of a set until its final result is taken.
// A stall on m_tready holds the current result and pauses the emission sequence.
// Reset (aresetn low, synchronous) empties the set and returns to loading; the
// store contents are not cleared.
module cocktail_shaker_sorter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,
    output logic        m_tuser    // [0] overflowed
);

    import css_pkg::*;

    mem_req_t mem_req;
    value_t   rd_data;
    cmp_req_t cmp_req;
    cmp_res_t cmp_res;

    css_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .cmp_req  (cmp_req),
        .cmp_res  (cmp_res)
    );

    css_cmpx u_cmpx (
        .cmp_req    (cmp_req),
        .next_value (rd_data),
        .cmp_res    (cmp_res)
    );

    css_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

endmodule
